// File: design/fsr_pkg.sv
package fsr_pkg;

	localparam int IN_WIDTH_DEF  = 16;
	localparam int ACC_WIDTH_DEF = 32;
	localparam int OUT_NUM_W     = 32;
	localparam int OUT_DEN_W     = 31;
	localparam int STAT_W        = 2;
	localparam int MAG_W         = 64;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVF  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ZDEN = 2'd2;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL1,
		OP_MUL2,
		OP_MUL3,
		OP_ADD,
		OP_GCD_INIT,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_GCD_NEXT,
		OP_RED_INIT,
		OP_RED_NUM_DONE,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic zero_den;
		logic ovf;
		logic mul_done;
		logic div_done;
		logic rem_zero;
	} stat_t;

endpackage

// File: design/fsr_datapath.sv
module fsr_datapath #(
	parameter int IN_WIDTH  = fsr_pkg::IN_WIDTH_DEF,
	parameter int ACC_WIDTH = fsr_pkg::ACC_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fsr_pkg::cmd_t                   cmd,
	output fsr_pkg::stat_t                  stat,
	input  logic signed [IN_WIDTH-1:0]      in_num,
	input  logic signed [IN_WIDTH-1:0]      in_den,
	input  logic                            in_first,
	output logic [fsr_pkg::OUT_NUM_W-1:0]   res_num,
	output logic [fsr_pkg::OUT_DEN_W-1:0]   res_den,
	output logic [fsr_pkg::STAT_W-1:0]      res_stat
);
	import fsr_pkg::*;

	localparam int CW = $clog2(MAG_W + 1);

	// accumulator
	logic                 acc_neg_q;
	logic [MAG_W-1:0]     acc_n_q, acc_d_q;
	logic [STAT_W-1:0]    sticky_q;

	// item operands
	logic                 nneg_q;
	logic [MAG_W-1:0]     nmag_q, dmag_q;
	logic                 zden_q;

	// products and working values
	logic [MAG_W-1:0]     t1_q, t2_q, den_q, mag_q;
	logic                 neg_q, ovf_q;

	// shift-add multiplier registers, and the counter shared with the restoring divider
	logic [MAG_W-1:0]     ma_q, mb_q;
	logic [MAG_W:0]       mp_q;
	logic [CW-1:0]        cnt_q;

	// gcd / divider
	logic [MAG_W-1:0]     ga_q, gb_q;
	logic [MAG_W-1:0]     dq_q, dr_q, dd_q, dv_q;

	logic [IN_WIDTH-1:0]  nabs, dabs;
	logic [MAG_W-1:0]     nmag_w, dmag_w;
	logic [MAG_W:0]       sum_w;
	logic [MAG_W:0]       trial;
	logic [MAG_W-1:0]     lim;

	assign nabs   = in_num[IN_WIDTH-1] ? IN_WIDTH'(-in_num) : IN_WIDTH'(in_num);
	assign dabs   = in_den[IN_WIDTH-1] ? IN_WIDTH'(-in_den) : IN_WIDTH'(in_den);
	assign nmag_w = MAG_W'(nabs) | (in_num[IN_WIDTH-1] && nabs == '0
		? (MAG_W'(1) << (IN_WIDTH-1)) : '0);
	assign dmag_w = MAG_W'(dabs) | (in_den[IN_WIDTH-1] && dabs == '0
		? (MAG_W'(1) << (IN_WIDTH-1)) : '0);
	assign sum_w  = {1'b0, t1_q} + {1'b0, t2_q};
	assign trial  = {dr_q, dd_q[MAG_W-1]};
	assign lim    = MAG_W'(1) << (ACC_WIDTH-1);

	assign stat.zero_den = zden_q;
	assign stat.ovf      = ovf_q;
	assign stat.mul_done = (cnt_q == '0);
	assign stat.div_done = (cnt_q == '0);
	assign stat.rem_zero = (gb_q == '0);

	assign res_num  = OUT_NUM_W'(acc_neg_q ? (MAG_W'(0) - acc_n_q) : acc_n_q);
	assign res_den  = OUT_DEN_W'(acc_d_q);
	assign res_stat = sticky_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_neg_q <= 1'b0;
			acc_n_q   <= '0;
			acc_d_q   <= MAG_W'(1);
			sticky_q  <= STAT_OK;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			zden_q    <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					if (in_first) begin
						acc_neg_q <= 1'b0;
						acc_n_q   <= '0;
						acc_d_q   <= MAG_W'(1);
					end
					zden_q <= (dmag_w == '0);
					nneg_q <= (nmag_w != '0) && (in_num[IN_WIDTH-1] ^ in_den[IN_WIDTH-1]);
					nmag_q <= nmag_w;
					dmag_q <= dmag_w;
					ovf_q  <= 1'b0;
					if (dmag_w == '0)
						sticky_q <= STAT_ZDEN;
					else if (in_first)
						sticky_q <= STAT_OK;
					// first product: acc_n * dmag
					ma_q  <= in_first ? '0 : acc_n_q;
					mb_q  <= dmag_w;
					mp_q  <= '0;
					cnt_q <= CW'(MAG_W);
				end
				OP_MUL1, OP_MUL2, OP_MUL3: begin
					if (cnt_q != '0) begin
						// shift-add, msb first, overflow when any carry leaves 64 bits
						logic [MAG_W+1:0] nx;
						nx = {mp_q, 1'b0} + (mb_q[MAG_W-1] ? {2'b0, ma_q} : '0);
						if (mp_q[MAG_W] || mp_q[MAG_W-1] || nx[MAG_W+1] || nx[MAG_W])
							ovf_q <= 1'b1;
						mp_q  <= nx[MAG_W:0];
						mb_q  <= mb_q << 1;
						cnt_q <= cnt_q - CW'(1);
					end else begin
						unique case (cmd.op)
							OP_MUL1: begin
								t1_q <= mp_q[MAG_W-1:0];
								ma_q <= nmag_q;
								mb_q <= acc_d_q;
							end
							OP_MUL2: begin
								t2_q <= mp_q[MAG_W-1:0];
								ma_q <= acc_d_q;
								mb_q <= dmag_q;
							end
							default: den_q <= mp_q[MAG_W-1:0];
						endcase
						mp_q  <= '0;
						cnt_q <= (cmd.op == OP_MUL3) ? '0 : CW'(MAG_W);
					end
				end
				OP_ADD: begin
					if (acc_neg_q == nneg_q) begin
						if (sum_w[MAG_W]) ovf_q <= 1'b1;
						mag_q <= sum_w[MAG_W-1:0];
						neg_q <= acc_neg_q && sum_w[MAG_W-1:0] != '0;
					end else if (t1_q >= t2_q) begin
						mag_q <= t1_q - t2_q;
						neg_q <= acc_neg_q && t1_q != t2_q;
					end else begin
						mag_q <= t2_q - t1_q;
						neg_q <= nneg_q;
					end
				end
				OP_GCD_INIT: begin
					ga_q <= mag_q;
					gb_q <= den_q;
				end
				OP_DIV_START: begin
					// dividend in dd, divisor in dv, one quotient bit per cycle
					dd_q  <= ga_q;
					dv_q  <= gb_q;
					dr_q  <= '0;
					dq_q  <= '0;
					cnt_q <= CW'(MAG_W);
				end
				OP_DIV_STEP: begin
					if (trial >= {1'b0, dv_q}) begin
						dr_q <= MAG_W'(trial - {1'b0, dv_q});
						dq_q <= {dq_q[MAG_W-2:0], 1'b1};
					end else begin
						dr_q <= trial[MAG_W-1:0];
						dq_q <= {dq_q[MAG_W-2:0], 1'b0};
					end
					dd_q  <= dd_q << 1;
					cnt_q <= cnt_q - CW'(1);
				end
				OP_GCD_NEXT: begin
					ga_q <= gb_q;
					gb_q <= dr_q;
				end
				OP_RED_INIT: begin
					// ga holds the gcd: divide mag first
					dd_q  <= mag_q;
					dv_q  <= ga_q;
					dr_q  <= '0;
					dq_q  <= '0;
					cnt_q <= CW'(MAG_W);
				end
				OP_RED_NUM_DONE: begin
					mag_q <= dq_q;
					dd_q  <= den_q;
					dr_q  <= '0;
					dq_q  <= '0;
					cnt_q <= CW'(MAG_W);
				end
				OP_COMMIT: begin
					// dq holds the reduced denominator
					if (ovf_q || dq_q > lim - MAG_W'(1) || (!neg_q && mag_q > lim - MAG_W'(1))
							|| (neg_q && mag_q > lim)) begin
						if (sticky_q == STAT_OK)
							sticky_q <= STAT_OVF;
					end else begin
						acc_neg_q <= neg_q;
						acc_n_q   <= mag_q;
						acc_d_q   <= dq_q;
					end
				end
				default: ;
			endcase
			// overflow from the multiply chain aborts into commit
			if (cmd.op == OP_ADD && ovf_q && sticky_q == STAT_OK)
				sticky_q <= STAT_OVF;
		end
	end

endmodule

// File: design/fsr_ctrl.sv
module fsr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_last,
	output logic           out_valid,
	input  logic           out_ready,
	output fsr_pkg::cmd_t  cmd,
	input  fsr_pkg::stat_t stat
);
	import fsr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_GCD_INIT, S_GCD_TEST,
		S_GCD_DIV, S_GCD_NEXT, S_RED_NUM, S_RED_DEN, S_COMMIT, S_OUT
	} state_t;

	state_t state_q;
	logic   last_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:     cmd.op = (in_valid) ? OP_LOAD : OP_NONE;
			S_MUL1:     cmd.op = OP_MUL1;
			S_MUL2:     cmd.op = OP_MUL2;
			S_MUL3:     cmd.op = OP_MUL3;
			S_ADD:      cmd.op = OP_ADD;
			S_GCD_INIT: cmd.op = OP_GCD_INIT;
			S_CHECK:    cmd.op = OP_NONE;
			S_GCD_TEST: cmd.op = stat.rem_zero ? OP_RED_INIT : OP_DIV_START;
			S_GCD_DIV:  cmd.op = stat.div_done ? OP_GCD_NEXT : OP_DIV_STEP;
			S_GCD_NEXT: cmd.op = OP_NONE;
			S_RED_NUM:  cmd.op = stat.div_done ? OP_RED_NUM_DONE : OP_DIV_STEP;
			S_RED_DEN:  cmd.op = stat.div_done ? OP_COMMIT : OP_DIV_STEP;
			S_COMMIT:   cmd.op = OP_NONE;
			S_OUT:      cmd.op = OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					last_q  <= in_last;
					state_q <= S_CHECK;
				end
				S_CHECK: state_q <= stat.zero_den ? S_COMMIT : S_MUL1;
				S_MUL1: if (stat.mul_done) state_q <= S_MUL2;
				S_MUL2: if (stat.mul_done) state_q <= S_MUL3;
				S_MUL3: if (stat.mul_done) state_q <= S_ADD;
				S_ADD: state_q <= stat.ovf ? S_COMMIT : S_GCD_INIT;
				S_GCD_INIT: state_q <= S_GCD_TEST;
				S_GCD_TEST: state_q <= stat.rem_zero ? S_RED_NUM : S_GCD_DIV;
				S_GCD_DIV: if (stat.div_done) state_q <= S_GCD_NEXT;
				S_GCD_NEXT: state_q <= S_GCD_TEST;
				S_RED_NUM: if (stat.div_done) state_q <= S_RED_DEN;
				S_RED_DEN: if (stat.div_done) state_q <= S_COMMIT;
				S_COMMIT: begin
					if (last_q) begin
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/fraction_sum_reducer_unit.sv
// a zero denominator goes straight to the commit state, and a product overflow skips the
// euclid rounds and the reduction
// work: three shift-add multiplies, one restoring division per euclid round (at least one),
// then two divisions by the gcd
// throughput: one transaction at a time, the next is taken only once the last finishes
// reset: arst_n clears the sum to 0/1, status to ok and the controller to idle
module fraction_sum_reducer_unit #(
	parameter int IN_WIDTH  = fsr_pkg::IN_WIDTH_DEF,
	parameter int ACC_WIDTH = fsr_pkg::ACC_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [2*IN_WIDTH-1:0]     s_tdata,   // numerator (low half), denominator (high half)
	input  logic                      s_tuser,   // first
	input  logic                      s_tlast,   // last
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [71:0]               m_tdata    // sum_numerator (low bits), sum_denominator, status (high bits)
);
	import fsr_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [OUT_NUM_W-1:0] res_num;
	logic [OUT_DEN_W-1:0] res_den;
	logic [STAT_W-1:0]    res_stat;

	// sequencer: one transaction in flight, result held until taken
	fsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_last  (s_tlast),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// accumulator, multiplier, divider and euclid registers
	fsr_datapath #(
		.IN_WIDTH (IN_WIDTH),
		.ACC_WIDTH(ACC_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_num   (s_tdata[IN_WIDTH-1:0]),
		.in_den   (s_tdata[2*IN_WIDTH-1:IN_WIDTH]),
		.in_first (s_tuser),
		.res_num  (res_num),
		.res_den  (res_den),
		.res_stat (res_stat)
	);

	// accumulator only changes while busy, so it is stable while m_tvalid is high
	assign m_tdata = {7'd0, res_stat, res_den, res_num};

endmodule
